### rtl/rcsa_pkg.sv
// Shared constants, codes and word types for the refcounted slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package rcsa_pkg;

	localparam int NUM_SLOTS  = 1024;
	localparam int COUNT_BITS = 16;
	localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
	localparam int TOP_BITS   = $clog2(NUM_SLOTS + 1);

	// Field widths of the command and result words
	localparam int CMD_W      = 2;
	localparam int SLOT_W     = 10;
	localparam int STATUS_W   = 3;
	localparam int CNT_OUT_W  = 16;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	// Compare width that holds slots, limits and the slot count itself
	localparam int CMP_BITS   = (TOP_BITS > CFG_DATA_W) ? TOP_BITS : CFG_DATA_W;

	localparam logic [CFG_DATA_W-1:0] SLOTS_RESET = CFG_DATA_W'(1024);

	localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOOTSTRAP    = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SLOT_W-1:0] slot_number;
	} request_t;

	typedef struct packed {
		logic [SLOT_W-1:0]    granted_slot;
		logic [STATUS_W-1:0]  status;
		logic [CNT_OUT_W-1:0] count_after;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // latch the command word, issue memory reads
		logic init_begin;  // empty the free stack
		logic exec;        // execute alloc, lookup or release
		logic sweep;       // write one count entry of the sweep
		logic sweep_init;  // sweep rebuilds the stack and seeds the bootstrap slot
		logic emit_init;   // present the init result
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_last;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/rcsa_ctrl.sv
// Controller state machine of the refcounted slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module rcsa_ctrl (
	input  wire                logic          clk,
	input  wire                logic          arst_n,
	input  wire                logic          start,
	input  wire                logic [rcsa_pkg::CMD_W-1:0] command,
	input  wire                rcsa_pkg::dp_status_t       dp_status,
	output logic                              busy,
	output rcsa_pkg::dp_cmd_t                 dp_cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_INIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		dp_cmd    = '0;
		unique case (state_q)
			S_CLEAR: begin
				dp_cmd.sweep = 1'b1;
				if (dp_status.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					dp_cmd.capture = 1'b1;
					if (command == rcsa_pkg::CMD_INIT) begin
						dp_cmd.init_begin = 1'b1;
						state_nxt = S_INIT;
					end else begin
						state_nxt = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				dp_cmd.exec = 1'b1;
				state_nxt   = S_IDLE;
			end
			S_INIT: begin
				dp_cmd.sweep      = 1'b1;
				dp_cmd.sweep_init = 1'b1;
				if (dp_status.sweep_last) begin
					dp_cmd.emit_init = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/rcsa_dp.sv
// Datapath of the refcounted slot allocator: count and stack memories, stack top, result word.
`timescale 1ns / 1ps
`default_nettype none

module rcsa_dp (
	input  wire                logic                              clk,
	input  wire                logic                              arst_n,
	input  wire                rcsa_pkg::request_t                request,
	input  wire                rcsa_pkg::dp_cmd_t                 dp_cmd,
	output rcsa_pkg::dp_status_t                                  dp_status,
	input  wire                logic                              cfg_valid,
	input  wire                logic [rcsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire                logic [rcsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                                  done,
	output rcsa_pkg::result_t                                     result
);

	localparam int SB = rcsa_pkg::SLOT_BITS;
	localparam int TB = rcsa_pkg::TOP_BITS;
	localparam int CB = rcsa_pkg::COUNT_BITS;
	localparam int MB = rcsa_pkg::CMP_BITS;
	localparam logic [CB-1:0] COUNT_MAX = '1;

	// Memories
	logic [CB-1:0] count_mem [rcsa_pkg::NUM_SLOTS];
	logic [SB-1:0] stack_mem [rcsa_pkg::NUM_SLOTS];

	// Configuration
	logic [rcsa_pkg::CFG_DATA_W-1:0] slots_in_use_q;
	logic [rcsa_pkg::SLOT_W-1:0]     bootstrap_q;

	// Control state
	logic [TB-1:0] top_q;
	logic [TB-1:0] top_nxt;
	logic [SB-1:0] sweep_cnt_q;
	logic          done_q;

	// Latched command word and read data
	logic [rcsa_pkg::CMD_W-1:0]  cmd_q;
	logic [rcsa_pkg::SLOT_W-1:0] slot_q;
	logic [CB-1:0]               count_rd_q;
	logic [SB-1:0]               stack_rd_q;
	rcsa_pkg::result_t           result_q;
	rcsa_pkg::result_t           res_nxt;

	// Memory write controls
	logic          cnt_we;
	logic [SB-1:0] cnt_waddr;
	logic [CB-1:0] cnt_wdata;
	logic          stk_we;
	logic [SB-1:0] stk_waddr;
	logic [SB-1:0] stk_wdata;

	// Range checks
	logic [MB-1:0] num_ext;
	logic [MB-1:0] siu_ext;
	logic [MB-1:0] lim;
	logic [MB-1:0] slot_ext;
	logic [MB-1:0] cnt_ext;
	logic          slot_valid;
	logic          cnt_in_range;
	logic          cnt_is_boot;
	logic          top_full;
	logic          sweep_last;
	logic [SB-1:0] slot_addr;
	logic [CB-1:0] count_inc;
	logic [CB-1:0] count_dec;

	assign num_ext      = MB'(rcsa_pkg::NUM_SLOTS);
	assign siu_ext      = MB'(slots_in_use_q);
	assign lim          = (siu_ext < num_ext) ? siu_ext : num_ext;
	assign slot_ext     = MB'(slot_q);
	assign cnt_ext      = MB'(sweep_cnt_q);
	assign slot_valid   = (slot_ext < num_ext) &&
		((slot_ext < lim) || (slot_q == bootstrap_q));
	assign cnt_in_range = (cnt_ext < lim);
	assign cnt_is_boot  = (cnt_ext == MB'(bootstrap_q));
	assign top_full     = (top_q == TB'(rcsa_pkg::NUM_SLOTS));
	assign sweep_last   = (sweep_cnt_q == SB'(rcsa_pkg::NUM_SLOTS - 1));
	assign slot_addr    = SB'(slot_q);
	assign count_inc    = count_rd_q + CB'(1);
	assign count_dec    = count_rd_q - CB'(1);

	assign dp_status.sweep_last = sweep_last;

	always_comb begin
		res_nxt   = '0;
		top_nxt   = top_q;
		cnt_we    = 1'b0;
		cnt_waddr = sweep_cnt_q;
		cnt_wdata = '0;
		stk_we    = 1'b0;
		stk_waddr = SB'(top_q);
		stk_wdata = sweep_cnt_q;

		if (dp_cmd.init_begin) begin
			top_nxt = '0;
		end

		if (dp_cmd.sweep) begin
			cnt_we = 1'b1;
			if (dp_cmd.sweep_init && cnt_is_boot) begin
				cnt_wdata = CB'(3);
			end
			// Push slots below the limit in ascending order, skip slot zero and the bootstrap slot
			if (dp_cmd.sweep_init && (sweep_cnt_q != '0) && cnt_in_range &&
				!cnt_is_boot && !top_full) begin
				stk_we  = 1'b1;
				top_nxt = top_q + TB'(1);
			end
		end

		if (dp_cmd.exec) begin
			unique case (cmd_q)
				rcsa_pkg::CMD_INIT: begin
					res_nxt.status = rcsa_pkg::ST_OK;
				end
				rcsa_pkg::CMD_ALLOC: begin
					if (top_q == '0) begin
						res_nxt.status = rcsa_pkg::ST_NO_FREE;
					end else begin
						top_nxt              = top_q - TB'(1);
						cnt_we               = 1'b1;
						cnt_waddr            = stack_rd_q;
						cnt_wdata            = CB'(1);
						res_nxt.status       = rcsa_pkg::ST_OK;
						res_nxt.granted_slot = rcsa_pkg::SLOT_W'(stack_rd_q);
						res_nxt.count_after  = rcsa_pkg::CNT_OUT_W'(1);
					end
				end
				rcsa_pkg::CMD_LOOKUP: begin
					if (!slot_valid || (count_rd_q == '0)) begin
						res_nxt.status = rcsa_pkg::ST_NOT_FOUND;
					end else if (count_rd_q == COUNT_MAX) begin
						res_nxt.status      = rcsa_pkg::ST_OVERFLOW;
						res_nxt.count_after = rcsa_pkg::CNT_OUT_W'(count_rd_q);
					end else begin
						cnt_we               = 1'b1;
						cnt_waddr            = slot_addr;
						cnt_wdata            = count_inc;
						res_nxt.status       = rcsa_pkg::ST_OK;
						res_nxt.granted_slot = slot_q;
						res_nxt.count_after  = rcsa_pkg::CNT_OUT_W'(count_inc);
					end
				end
				rcsa_pkg::CMD_RELEASE: begin
					if (!slot_valid || (count_rd_q == '0)) begin
						res_nxt.status = rcsa_pkg::ST_BAD_RELEASE;
					end else begin
						cnt_we    = 1'b1;
						cnt_waddr = slot_addr;
						cnt_wdata = count_dec;
						if (count_dec == '0) begin
							res_nxt.status = rcsa_pkg::ST_FREED;
							if (!top_full) begin
								stk_we    = 1'b1;
								stk_wdata = slot_addr;
								top_nxt   = top_q + TB'(1);
							end
						end else begin
							res_nxt.status      = rcsa_pkg::ST_OK;
							res_nxt.count_after = rcsa_pkg::CNT_OUT_W'(count_dec);
						end
					end
				end
				default: begin
					res_nxt.status = rcsa_pkg::ST_OK;
				end
			endcase
		end
	end

	// Count memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[cnt_waddr] <= cnt_wdata;
		end
		if (dp_cmd.capture) begin
			count_rd_q <= count_mem[SB'(request.slot_number)];
		end
	end

	// Free stack memory: read the top entry at accept
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (dp_cmd.capture) begin
			stack_rd_q <= stack_mem[SB'(top_q - TB'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q  <= request.command;
			slot_q <= request.slot_number;
		end
		if (dp_cmd.exec || dp_cmd.emit_init) begin
			result_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= rcsa_pkg::SLOTS_RESET;
			bootstrap_q    <= '0;
			top_q          <= '0;
			sweep_cnt_q    <= '0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					rcsa_pkg::REG_SLOTS_IN_USE: slots_in_use_q <= cfg_data;
					rcsa_pkg::REG_BOOTSTRAP:    bootstrap_q <= cfg_data[rcsa_pkg::SLOT_W-1:0];
					default:                    bootstrap_q <= bootstrap_q;
				endcase
			end
			top_q  <= top_nxt;
			done_q <= dp_cmd.exec || dp_cmd.emit_init;
			if (dp_cmd.sweep) begin
				sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + SB'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### rtl/refcounted_slot_allocator.sv
// Top level of the refcounted slot allocator: controller plus datapath.
//
//  channel   ports                              handshake
//  command   start, busy, request               taken when start && !busy
//  result    done, result                       one-cycle strobe, cannot stall
//  config    cfg_valid, cfg_ready, cfg_index,   write when cfg_valid && cfg_ready
//            cfg_data
//
// Alloc, lookup and release read the count and stack memories when the command is taken, then
// read-modify-write them in the execute state; the result word and done are registered together.
// Init walks all 1024 count entries, one a cycle, and rebuilds the free stack.
// After reset a clearing pass zeroes all 1024 counts while busy is high.
// Config writes are taken in every cycle; results must be taken when done is high.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_slot_allocator (
	input  wire                logic                            clk,
	input  wire                logic                            arst_n,
	input  wire                logic                            start,
	output logic                                                busy,
	input  wire                rcsa_pkg::request_t              request,
	output logic                                                done,
	output rcsa_pkg::result_t                                   result,
	input  wire                logic                            cfg_valid,
	output logic                                                cfg_ready,
	input  wire                logic [rcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire                logic [rcsa_pkg::CFG_DATA_W-1:0] cfg_data
);

	rcsa_pkg::dp_cmd_t    dp_cmd;
	rcsa_pkg::dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	rcsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (request.command),
		.dp_status (dp_status),
		.busy      (busy),
		.dp_cmd    (dp_cmd)
	);

	rcsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire
